// ----- design/cpc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cpc_pkg;

    localparam int POS_W  = 31;
    localparam int LEN_W  = 28;
    localparam int CODE_W = 4;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // sam cigar operation codes
    localparam logic [CODE_W-1:0] CIGAR_M  = 4'd0;
    localparam logic [CODE_W-1:0] CIGAR_I  = 4'd1;
    localparam logic [CODE_W-1:0] CIGAR_D  = 4'd2;
    localparam logic [CODE_W-1:0] CIGAR_N  = 4'd3;
    localparam logic [CODE_W-1:0] CIGAR_S  = 4'd4;
    localparam logic [CODE_W-1:0] CIGAR_EQ = 4'd7;
    localparam logic [CODE_W-1:0] CIGAR_X  = 4'd8;

    // direction of the conversion
    localparam logic OP_QUERY_TO_REF = 1'b0;
    localparam logic OP_REF_TO_QUERY = 1'b1;

    typedef struct packed {
        logic              operation;
        logic              first_element;
        logic              last_element;
        logic [CODE_W-1:0] op_code;
        logic [LEN_W-1:0]  op_length;
        logic [POS_W-1:0]  align_start;
        logic [POS_W-1:0]  target_pos;
    } elem_t;

    function automatic logic is_match(input logic [CODE_W-1:0] code);
        is_match = (code == CIGAR_M) || (code == CIGAR_EQ) || (code == CIGAR_X);
    endfunction

    function automatic logic consumes_query(input logic [CODE_W-1:0] code);
        consumes_query = is_match(code) || (code == CIGAR_I) || (code == CIGAR_S);
    endfunction

    function automatic logic consumes_ref(input logic [CODE_W-1:0] code);
        consumes_ref = is_match(code) || (code == CIGAR_D) || (code == CIGAR_N);
    endfunction

    function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                                input logic [POS_W:0]   b);
        logic [POS_W+1:0] s;
        s = {2'b00, a} + {1'b0, b};
        if (s > {2'b00, POS_MAX})
        begin
            sat_add = POS_MAX;
        end
        else
        begin
            sat_add = s[POS_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ----- design/cpc_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cpc_in_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire cpc_pkg::elem_t in_elem,
    input  wire logic          take,
    output logic               elem_valid,
    output cpc_pkg::elem_t     elem
);

    logic           valid_reg;
    logic           valid_next;
    cpc_pkg::elem_t elem_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            elem_reg <= in_elem;
        end
    end

    assign elem_valid = valid_reg;
    assign elem       = elem_reg;

endmodule

`default_nettype wire

// ----- design/cpc_step.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cpc_step (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    fire,
    input  wire cpc_pkg::elem_t          elem,
    output logic                         found,
    output logic [cpc_pkg::POS_W-1:0]    mapped_pos
);

    logic [cpc_pkg::POS_W-1:0] query_count_reg, query_count_next;
    logic [cpc_pkg::POS_W-1:0] ref_count_reg, ref_count_next;
    logic                      hit_flag_reg, hit_flag_next;
    logic [cpc_pkg::POS_W-1:0] hit_position_reg, hit_position_next;

    logic [cpc_pkg::POS_W-1:0] q0, r0, p0, searched, other;
    logic                      h0, allowed, hit_now, frozen;
    logic [cpc_pkg::POS_W:0]   span_end;
    logic [cpc_pkg::POS_W:0]   len_ext;
    logic [cpc_pkg::POS_W:0]   target_gap;

    always_comb
    begin
        q0 = elem.first_element ? '0 : query_count_reg;
        r0 = elem.first_element ? elem.align_start : ref_count_reg;
        h0 = elem.first_element ? 1'b0 : hit_flag_reg;
        p0 = elem.first_element ? '0 : hit_position_reg;

        searched = (elem.operation == cpc_pkg::OP_REF_TO_QUERY) ? r0 : q0;
        other    = (elem.operation == cpc_pkg::OP_REF_TO_QUERY) ? q0 : r0;
        allowed  = !((elem.operation == cpc_pkg::OP_REF_TO_QUERY)
                     && (elem.target_pos < elem.align_start));

        len_ext    = {{(cpc_pkg::POS_W + 1 - cpc_pkg::LEN_W){1'b0}}, elem.op_length};
        span_end   = {1'b0, searched} + len_ext;
        target_gap = {1'b0, elem.target_pos - searched};

        // compare against the counter after its increment
        hit_now = !h0 && cpc_pkg::is_match(elem.op_code) && allowed
                  && (elem.op_length != '0)
                  && (elem.target_pos > searched)
                  && ({1'b0, elem.target_pos} <= span_end);

        frozen = h0 || hit_now;

        query_count_next = q0;
        ref_count_next   = r0;
        if (!frozen && cpc_pkg::consumes_query(elem.op_code))
        begin
            query_count_next = cpc_pkg::sat_add(q0, len_ext);
        end
        if (!frozen && cpc_pkg::consumes_ref(elem.op_code))
        begin
            ref_count_next = cpc_pkg::sat_add(r0, len_ext);
        end

        hit_flag_next     = frozen;
        hit_position_next = hit_now ? cpc_pkg::sat_add(other, target_gap) : p0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_count_reg  <= '0;
            ref_count_reg    <= '0;
            hit_flag_reg     <= 1'b0;
            hit_position_reg <= '0;
        end
        else if (fire)
        begin
            query_count_reg  <= query_count_next;
            ref_count_reg    <= ref_count_next;
            hit_flag_reg     <= hit_flag_next;
            hit_position_reg <= hit_position_next;
        end
    end

    assign found      = hit_flag_next;
    assign mapped_pos = hit_flag_next ? hit_position_next : '0;

endmodule

`default_nettype wire

// ----- design/cigar_position_convert.sv -----
`timescale 1ns / 1ps
`default_nettype none

// cigar position converter: walks the cigar of one alignment, one element per
// input transfer, and converts a query position to a reference position or
// back.
// input stream: one cigar element per transfer; tlast marks the last element
// of a read, tuser[1] the first one (counters restart), tuser[0] the direction
// (0 query to reference, 1 reference to query).
// output stream: one transfer per read, sent after its last element; tuser is
// the found flag, tdata the converted position (zero when not found).
// the result is registered: a last element passes the input register, then the
// counter update and the result register. throughput: one element per cycle
// unless a last element waits for the result register; the counter update is a
// single add, compare and saturate between the input and the state registers.
// reset clears the counters, the hit flag and both valid flags.
// while the receiver stalls, elements that emit nothing still flow; a last
// element waits in the input register until the result register is free,
// and the input side then stalls behind it.
module cigar_position_convert (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,  // op_code, op_length, align_start, target_pos
    input  wire logic [1:0]  s_axis_tuser,  // operation, first_element
    input  wire logic        s_axis_tlast,  // last_element
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // mapped_pos
    output logic             m_axis_tuser   // found
);

    cpc_pkg::elem_t            in_elem;
    cpc_pkg::elem_t            elem;
    logic                      elem_valid;
    logic                      out_free;
    logic                      fire;
    logic                      found;
    logic [cpc_pkg::POS_W-1:0] mapped_pos;

    logic                      out_valid_reg;
    logic                      out_found_reg;
    logic [cpc_pkg::POS_W-1:0] out_pos_reg;

    assign in_elem.operation     = s_axis_tuser[0];
    assign in_elem.first_element = s_axis_tuser[1];
    assign in_elem.last_element  = s_axis_tlast;
    assign in_elem.op_code       = s_axis_tdata[3:0];
    assign in_elem.op_length     = s_axis_tdata[31:4];
    assign in_elem.align_start   = s_axis_tdata[62:32];
    assign in_elem.target_pos    = s_axis_tdata[93:63];

    assign out_free = !out_valid_reg || m_axis_tready;
    assign fire     = elem_valid && (!elem.last_element || out_free);

    cpc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_elem    (in_elem),
        .take       (fire),
        .elem_valid (elem_valid),
        .elem       (elem)
    );

    cpc_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .elem       (elem),
        .found      (found),
        .mapped_pos (mapped_pos)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && elem.last_element)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && elem.last_element)
        begin
            out_found_reg <= found;
            out_pos_reg   <= mapped_pos;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_pos_reg};
    assign m_axis_tuser  = out_found_reg;

    // a position is only reported with a hit
    a_pos_zero_without_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("mapped position nonzero without a hit");

    // a new result only follows a last element leaving the input register
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(fire && elem.last_element))
        else $error("result without a last element");

    // input side only stalls when the input register is occupied
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (elem_valid && elem.last_element && !out_free))
        else $error("input stalled without a blocked last element");

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam logic [cpc_pkg::LEN_W-1:0] LEN_MAX = {cpc_pkg::LEN_W{1'b1}};
    localparam int LEN_PAD = cpc_pkg::POS_W + 1 - cpc_pkg::LEN_W;

    typedef struct packed {
        logic                      found;
        logic [cpc_pkg::POS_W-1:0] mapped_pos;
    } conv_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;  // op_code, op_length, align_start, target_pos
    logic [1:0]  s_axis_tuser = '0;  // operation, first_element
    logic        s_axis_tlast = 1'b0;  // last_element
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;  // mapped_pos
    logic        m_axis_tuser;  // found

    // predictor state
    logic [cpc_pkg::POS_W-1:0] query_ctr = '0;
    logic [cpc_pkg::POS_W-1:0] ref_pos = '0;
    logic                      hit_seen = 1'b0;
    logic [cpc_pkg::POS_W-1:0] hit_mapped = '0;

    conv_result_t pending_conv[$];
    conv_result_t oldest_conv;
    int           err_count = 0;
    int           items_sent = 0;
    bit           idle_en = 1'b1;
    int           hold_req = 0;
    int           hold_left = 0;
    int           stall_left = 0;

    cigar_position_convert dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 clk = ~clk;

    function automatic logic [cpc_pkg::POS_W-1:0] clamp_pos_add(
            input logic [cpc_pkg::POS_W-1:0] a, input logic [cpc_pkg::POS_W:0] b);
        logic [cpc_pkg::POS_W+1:0] s;
        s = {2'b00, a} + {1'b0, b};
        if (s > {2'b00, cpc_pkg::POS_MAX})
        begin
            return cpc_pkg::POS_MAX;
        end
        return s[cpc_pkg::POS_W-1:0];
    endfunction

    // advances the cigar walk by one element; a last element yields a result
    function automatic void walk_cigar_elem(input cpc_pkg::elem_t e, output logic has_result,
                                            output conv_result_t res);
        logic                      matching;
        logic                      eats_query;
        logic                      eats_ref;
        logic [cpc_pkg::POS_W-1:0] searched;
        logic [cpc_pkg::POS_W-1:0] other;
        logic [cpc_pkg::POS_W:0]   len_ext;
        logic [cpc_pkg::POS_W:0]   span_end;
        matching = 1'b0;
        eats_query = 1'b0;
        eats_ref = 1'b0;
        len_ext = {{LEN_PAD{1'b0}}, e.op_length};
        case (e.op_code)
            cpc_pkg::CIGAR_M, cpc_pkg::CIGAR_EQ, cpc_pkg::CIGAR_X:
            begin
                matching = 1'b1;
                eats_query = 1'b1;
                eats_ref = 1'b1;
            end
            cpc_pkg::CIGAR_I, cpc_pkg::CIGAR_S: eats_query = 1'b1;
            cpc_pkg::CIGAR_D, cpc_pkg::CIGAR_N: eats_ref = 1'b1;
            default: ;
        endcase
        if (e.first_element)
        begin
            query_ctr = '0;
            ref_pos = e.align_start;
            hit_seen = 1'b0;
            hit_mapped = '0;
        end
        if (!hit_seen)
        begin
            if (matching)
            begin
                searched = (e.operation == cpc_pkg::OP_REF_TO_QUERY) ? ref_pos : query_ctr;
                other = (e.operation == cpc_pkg::OP_REF_TO_QUERY) ? query_ctr : ref_pos;
                span_end = {1'b0, searched} + len_ext;
                // hit compares the counter after its increment
                if (!(e.operation == cpc_pkg::OP_REF_TO_QUERY &&
                      e.target_pos < e.align_start) &&
                    e.op_length != '0 && e.target_pos > searched &&
                    {1'b0, e.target_pos} <= span_end)
                begin
                    hit_seen = 1'b1;
                    hit_mapped = clamp_pos_add(other, {1'b0, e.target_pos - searched});
                end
            end
            if (!hit_seen)
            begin
                if (eats_query)
                begin
                    query_ctr = clamp_pos_add(query_ctr, len_ext);
                end
                if (eats_ref)
                begin
                    ref_pos = clamp_pos_add(ref_pos, len_ext);
                end
            end
        end
        has_result = e.last_element;
        res.found = hit_seen;
        res.mapped_pos = hit_seen ? hit_mapped : '0;
    endfunction

    task automatic send_elem(input logic dir, input logic first, input logic last,
                             input logic [cpc_pkg::CODE_W-1:0] code,
                             input logic [cpc_pkg::LEN_W-1:0] len,
                             input logic [cpc_pkg::POS_W-1:0] start,
                             input logic [cpc_pkg::POS_W-1:0] target);
        cpc_pkg::elem_t e;
        logic           has_result;
        conv_result_t   res;
        bit             taken;
        e.operation = dir;
        e.first_element = first;
        e.last_element = last;
        e.op_code = code;
        e.op_length = len;
        e.align_start = start;
        e.target_pos = target;
        if (idle_en && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, target, start, len, code};
        s_axis_tuser <= {first, dir};
        s_axis_tlast <= last;
        do
        begin
            @(negedge clk);
            taken = s_axis_tready;
            @(posedge clk);
        end
        while (!taken);
        walk_cigar_elem(e, has_result, res);
        if (has_result)
        begin
            pending_conv.push_back(res);
        end
        items_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_conv.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // one read, mostly well formed, now and then with a flag dropped or a field changed
    task automatic send_random_read();
        int                           n;
        logic [cpc_pkg::POS_W-1:0]    off;
        logic [31:0]                  rnd;
        logic                         dir;
        logic                         first;
        logic                         last;
        logic [cpc_pkg::CODE_W-1:0]   code;
        logic [cpc_pkg::LEN_W-1:0]    len;
        logic [cpc_pkg::POS_W-1:0]    start;
        logic [cpc_pkg::POS_W-1:0]    elem_start;
        logic [cpc_pkg::POS_W-1:0]    target;
        n = $urandom_range(1, 8);
        rnd = $urandom_range(0, 1);
        dir = rnd[0];
        case ($urandom_range(0, 9))
            0: rnd = $urandom();
            1: rnd = {1'b0, cpc_pkg::POS_MAX} - $urandom_range(0, 1000);
            default: rnd = $urandom_range(0, 100000);
        endcase
        start = rnd[cpc_pkg::POS_W-1:0];
        rnd = $urandom_range(0, 40 * n + 5);
        off = rnd[cpc_pkg::POS_W-1:0];
        if (dir == cpc_pkg::OP_QUERY_TO_REF)
        begin
            target = off;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            target = (start > off) ? start - off : '0;
        end
        else
        begin
            target = clamp_pos_add(start, {1'b0, off});
        end
        if ($urandom_range(0, 11) == 0)
        begin
            rnd = $urandom();
            target = rnd[cpc_pkg::POS_W-1:0];
        end
        for (int i = 0; i < n; i++)
        begin
            first = (i == 0) && ($urandom_range(0, 11) != 0);
            last = (i == n - 1) && ($urandom_range(0, 14) != 0);
            case ($urandom_range(0, 19))
                0, 1, 2, 3: code = cpc_pkg::CIGAR_M;
                4, 5: code = cpc_pkg::CIGAR_EQ;
                6, 7: code = cpc_pkg::CIGAR_X;
                8, 9: code = cpc_pkg::CIGAR_I;
                10, 11: code = cpc_pkg::CIGAR_D;
                12: code = cpc_pkg::CIGAR_N;
                13, 14: code = cpc_pkg::CIGAR_S;
                default:
                begin
                    rnd = $urandom_range(0, (1 << cpc_pkg::CODE_W) - 1);
                    code = rnd[cpc_pkg::CODE_W-1:0];
                end
            endcase
            rnd = ($urandom_range(0, 14) == 0) ? $urandom() : $urandom_range(0, 40);
            len = rnd[cpc_pkg::LEN_W-1:0];
            if (i != 0 && $urandom_range(0, 3) == 0)
            begin
                rnd = $urandom();
                elem_start = rnd[cpc_pkg::POS_W-1:0];
            end
            else
            begin
                elem_start = start;
            end
            if (i != 0 && $urandom_range(0, 11) == 0)
            begin
                dir = ~dir;
            end
            send_elem(dir, first, last, code, len, elem_start, target);
        end
    endtask

    task automatic test_directed();
        // every code in one read, first one of zero length, target out of reach
        for (int c = 0; c < (1 << cpc_pkg::CODE_W); c++)
        begin
            send_elem(cpc_pkg::OP_QUERY_TO_REF, c == 0, c == (1 << cpc_pkg::CODE_W) - 1,
                      c[cpc_pkg::CODE_W-1:0], (c == 0) ? '0 : c[cpc_pkg::LEN_W-1:0], 50,
                      cpc_pkg::POS_MAX);
        end
        // a hit inside each match kind
        send_elem(cpc_pkg::OP_QUERY_TO_REF, 1'b1, 1'b1, cpc_pkg::CIGAR_M, 10, 100, 5);
        send_elem(cpc_pkg::OP_REF_TO_QUERY, 1'b1, 1'b1, cpc_pkg::CIGAR_EQ, 10, 100, 107);
        send_elem(cpc_pkg::OP_REF_TO_QUERY, 1'b1, 1'b1, cpc_pkg::CIGAR_X, 1, 200, 201);
        // query target zero is never reached
        send_elem(cpc_pkg::OP_QUERY_TO_REF, 1'b1, 1'b1, cpc_pkg::CIGAR_M, 20, 300, 0);
        // reference target below the alignment start
        send_elem(cpc_pkg::OP_REF_TO_QUERY, 1'b1, 1'b1, cpc_pkg::CIGAR_M, 20, 1000, 500);
        // reference counter saturates, then the mapped position too
        send_elem(cpc_pkg::OP_QUERY_TO_REF, 1'b1, 1'b0, cpc_pkg::CIGAR_D, LEN_MAX,
                  cpc_pkg::POS_MAX - 3, 4);
        send_elem(cpc_pkg::OP_QUERY_TO_REF, 1'b0, 1'b1, cpc_pkg::CIGAR_M, 10,
                  cpc_pkg::POS_MAX - 3, 4);
        // read without a first element carries the counters on
        send_elem(cpc_pkg::OP_QUERY_TO_REF, 1'b1, 1'b1, cpc_pkg::CIGAR_I, 7, 400,
                  cpc_pkg::POS_MAX);
        send_elem(cpc_pkg::OP_QUERY_TO_REF, 1'b0, 1'b1, cpc_pkg::CIGAR_M, 5, 0, 9);
        // all fields at their top
        send_elem(cpc_pkg::OP_REF_TO_QUERY, 1'b1, 1'b1, {cpc_pkg::CODE_W{1'b1}}, LEN_MAX,
                  cpc_pkg::POS_MAX, cpc_pkg::POS_MAX);
    endtask

    task automatic test_random_reads(input int item_goal);
        while (items_sent < item_goal)
        begin
            send_random_read();
        end
    endtask

    // receiver holds off while single-element reads keep coming
    task automatic test_backpressure();
        logic [31:0] r_dir;
        logic [31:0] r_len;
        logic [31:0] r_start;
        logic [31:0] r_tgt;
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        hold_req = 120;
        @(posedge clk);
        for (int i = 0; i < 40; i++)
        begin
            r_dir = $urandom_range(0, 1);
            r_len = $urandom_range(1, 30);
            r_start = $urandom_range(0, 50);
            r_tgt = $urandom_range(0, 60);
            send_elem(r_dir[0], 1'b1, 1'b1, cpc_pkg::CIGAR_M, r_len[cpc_pkg::LEN_W-1:0],
                      r_start[cpc_pkg::POS_W-1:0], r_tgt[cpc_pkg::POS_W-1:0]);
        end
    endtask

    task automatic test_pause();
        repeat (10) send_random_read();
        drain_results();
        repeat (10) send_random_read();
    endtask

    task automatic test_no_idle(input int item_goal);
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        idle_en = 1'b0;
        @(posedge clk);
        test_random_reads(item_goal);
    endtask

    // receiver side: random stall bursts and the long hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (!rst_n)
            begin
                m_axis_tready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // outputs are stable at the falling edge; a transfer there lands on the next rising one
    always @(negedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_conv.size() == 0)
            begin
                $error("result transfer with nothing expected: found %0d, mapped_pos %0d",
                       m_axis_tuser, m_axis_tdata[cpc_pkg::POS_W-1:0]);
                err_count++;
            end
            else
            begin
                oldest_conv = pending_conv.pop_front();
                if (m_axis_tuser !== oldest_conv.found)
                begin
                    $error("found: expected %0d, got %0d", oldest_conv.found, m_axis_tuser);
                    err_count++;
                end
                if (m_axis_tdata[cpc_pkg::POS_W-1:0] !== oldest_conv.mapped_pos)
                begin
                    $error("mapped_pos: expected %0d, got %0d", oldest_conv.mapped_pos,
                           m_axis_tdata[cpc_pkg::POS_W-1:0]);
                    err_count++;
                end
                if (m_axis_tdata[31] !== 1'b0)
                begin
                    $error("tdata pad: expected 0, got %b", m_axis_tdata[31]);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_reads(850);
        test_backpressure();
        test_pause();
        test_no_idle(1150);
        drain_results();
        repeat (8) @(posedge clk);
        if (err_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
